>>> rtl/core/assert_macros.svh
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property sampled on the rising clock edge and ignored while reset is held.
`define SPR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Implication that must hold in the cycle after its trigger.
`define SPR_ASSERT_NEXT(label, trig, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (prop)) \
		else $error(msg);

`endif

>>> rtl/core/spr_pkg.sv
package spr_pkg;

	localparam int RING_SLOTS_DEF = 4;
	localparam int SLOT_BYTES     = 256;
	localparam int BYTE_W         = 8;

	localparam logic [7:0]  START_BYTE = 8'hFF;
	localparam logic [7:0]  MIN_LEN    = 8'd2;
	localparam logic [7:0]  MAX_LEN    = 8'd250;
	localparam logic [7:0]  LEN_LIMIT  = 8'd254;
	localparam logic [7:0]  POS_ID     = 8'd2;
	localparam logic [7:0]  POS_LEN    = 8'd3;
	localparam logic [8:0]  HDR_BYTES  = 9'd4;

	localparam logic [7:0]  DEVICE_ID_RST    = 8'd1;
	localparam logic [7:0]  BROADCAST_ID_RST = 8'd254;
	localparam logic [15:0] TIMEOUT_RST      = 16'd2;

	typedef enum logic [1:0] {
		CMD_BYTE    = 2'd0,
		CMD_TICK    = 2'd1,
		CMD_RELEASE = 2'd2,
		CMD_READ    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		REG_DEVICE_ID    = 2'd0,
		REG_BROADCAST_ID = 2'd1,
		REG_TIMEOUT      = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		EV_STORED   = 3'd0,
		EV_REJECTED = 3'd1,
		EV_COMPLETE = 3'd2,
		EV_TIMEOUT  = 3'd3,
		EV_IDLE     = 3'd4,
		EV_RELEASED = 3'd5,
		EV_EMPTY    = 3'd6,
		EV_READ     = 3'd7
	} ev_t;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] rx_byte;
		logic       sync_read_active;
		logic [7:0] byte_index;
	} spr_in_t;

	typedef struct packed {
		logic [2:0] event_res;
		logic       packet_ready;
		logic       receiving;
		logic       error_flag;
		logic [7:0] read_data;
		logic [7:0] oldest_length;
		logic       cancel_sync_timeout;
	} spr_out_t;

endpackage

>>> rtl/core/spr_pkt_mem.sv
module spr_pkt_mem #(
	parameter int ADDR_W = 10
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [ADDR_W-1:0]           waddr,
	input  logic [spr_pkg::BYTE_W-1:0]  wdata,
	input  logic                        re,
	input  logic [ADDR_W-1:0]           raddr,
	output logic [spr_pkg::BYTE_W-1:0]  rdata
);

	logic [spr_pkg::BYTE_W-1:0] mem [2**ADDR_W];
	logic [spr_pkg::BYTE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read data holds until the next read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/core/spr_out_fifo.sv
module spr_out_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  spr_pkg::spr_out_t push_data,
	input  logic              stall,
	output logic              valid,
	output spr_pkg::spr_out_t head,
	output logic              pop,
	output logic [1:0]        count
);

	spr_pkg::spr_out_t ent_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        cnt_q;

	assign valid = (cnt_q != 2'd0);
	assign pop   = valid && !stall;
	assign head  = ent_q[rd_ptr_q];
	assign count = cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

>>> rtl/core/servo_packet_receiver_core.sv
// Servo packet receiver core.
// Requests enter on in_valid/in_stall carrying in_data: a received byte, a timer
// tick, a release of the oldest stored packet or a read of one of its bytes.
// Every request yields exactly one response on out_valid/out_stall (out_data),
// in request order. A transfer happens on a rising edge with valid high and
// stall low. Configuration (own id, broadcast id, timeout in ticks) is written
// through cfg_we/cfg_index/cfg_data; the user must do so only while no request
// is outstanding, as the block itself does not enforce this. An accepted
// request passes first through the state update and packet memory access,
// which are registered, and then through the two-entry output queue. One
// request is taken every cycle while in_stall is low; the rate is set by the
// single write port and the single read port of the packet memory, each used
// at most once per request. If the consumer stalls while the queue and the
// stage in front of it hold two responses between them, in_stall rises in
// that same cycle; the second queue entry catches the response still in
// flight, and in_stall falls in the cycle in which the consumer takes one.
// An asynchronous reset on arst_n empties the pipeline, the ring and the
// queue, clears the error flag and restores the configuration defaults; the
// packet memory is not cleared, as only bytes already written are ever read.
module servo_packet_receiver_core #(
	parameter int RING_SLOTS = spr_pkg::RING_SLOTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  spr_pkg::spr_in_t  in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output spr_pkg::spr_out_t out_data,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_data
);

	localparam int SLOT_W = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
	localparam int ADDR_W = SLOT_W + $clog2(spr_pkg::SLOT_BYTES);
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(RING_SLOTS - 1);

	// Configuration registers.
	logic [7:0]  dev_id_q;
	logic [7:0]  bc_id_q;
	logic [15:0] tmo_ticks_q;

	// Receiver state. cur_len_q is the live byte count of the slot being filled;
	// slot_len_q keeps the final count of each completed slot.
	logic [7:0]        cur_len_q;
	logic [7:0]        len_byte_q;
	logic [SLOT_W-1:0] ws_q;
	logic [SLOT_W-1:0] rs_q;
	logic              rx_q;
	logic [15:0]       tmo_q;
	logic              err_q;
	logic [7:0]        slot_len_q [RING_SLOTS];

	// First pipeline stage: response fields waiting for the memory read data.
	logic              valid_s1;
	spr_pkg::spr_out_t resp_s1;
	logic              hit_s1;

	logic accept;
	logic fifo_pop;
	logic [1:0] fifo_cnt;
	logic [2:0] inflight;

	function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
		return (s == LAST_SLOT) ? '0 : s + 1'b1;
	endfunction

	// Request decode and next-state logic.
	spr_pkg::cmd_t     cmd;
	logic [7:0]        rx_b;
	logic              sync;
	logic [7:0]        idx;
	logic [7:0]        len1;
	logic              reject;
	logic              complete;
	logic [7:0]        cur_len_n;
	logic [7:0]        len_byte_n;
	logic [SLOT_W-1:0] ws_n;
	logic [SLOT_W-1:0] rs_n;
	logic              rx_n;
	logic [15:0]       tmo_n;
	logic              err_n;
	logic              sl_we;
	logic              mem_we;
	logic              mem_re;
	logic              hit;
	logic              cancel;
	logic [7:0]        oldest;
	spr_pkg::ev_t      ev;

	assign cmd  = spr_pkg::cmd_t'(in_data.command);
	assign rx_b = in_data.rx_byte;
	assign sync = in_data.sync_read_active;
	assign idx  = in_data.byte_index;
	assign len1 = cur_len_q + 8'd1;

	always_comb begin
		cur_len_n  = cur_len_q;
		len_byte_n = len_byte_q;
		ws_n       = ws_q;
		rs_n       = rs_q;
		rx_n       = rx_q;
		tmo_n      = tmo_q;
		err_n      = err_q;
		sl_we      = 1'b0;
		mem_we     = 1'b0;
		mem_re     = 1'b0;
		hit        = 1'b0;
		cancel     = 1'b0;
		reject     = 1'b0;
		complete   = 1'b0;
		ev         = spr_pkg::EV_IDLE;
		case (cmd)
			spr_pkg::CMD_BYTE: begin
				reject = ((cur_len_q < spr_pkg::POS_ID) && (rx_b != spr_pkg::START_BYTE))
					|| ((cur_len_q == spr_pkg::POS_ID) && (rx_b != dev_id_q)
						&& (rx_b != bc_id_q) && !sync)
					|| ((cur_len_q == spr_pkg::POS_LEN)
						&& ((rx_b < spr_pkg::MIN_LEN) || (rx_b > spr_pkg::MAX_LEN)))
					|| (cur_len_q >= spr_pkg::LEN_LIMIT);
				if (reject) begin
					cur_len_n = 8'd0;
					rx_n      = 1'b0;
					tmo_n     = 16'd0;
					ev        = spr_pkg::EV_REJECTED;
				end else begin
					// The first start byte opens a reception and arms the timeout.
					if (cur_len_q == 8'd0) begin
						rx_n  = 1'b1;
						tmo_n = tmo_ticks_q;
					end
					mem_we = 1'b1;
					if (cur_len_q == spr_pkg::POS_LEN) begin
						len_byte_n = rx_b;
						cancel     = sync;
					end
					complete = (cur_len_q > spr_pkg::POS_LEN)
						&& ({1'b0, len1} == ({1'b0, len_byte_q} + spr_pkg::HDR_BYTES));
					if (complete) begin
						sl_we     = 1'b1;
						ws_n      = next_slot(ws_q);
						cur_len_n = 8'd0;
						rx_n      = 1'b0;
						tmo_n     = 16'd0;
						ev        = spr_pkg::EV_COMPLETE;
					end else begin
						cur_len_n = len1;
						ev        = spr_pkg::EV_STORED;
					end
				end
			end
			spr_pkg::CMD_TICK: begin
				if (!rx_q) begin
					ev = spr_pkg::EV_IDLE;
				end else if (tmo_q <= 16'd1) begin
					cur_len_n = 8'd0;
					rx_n      = 1'b0;
					tmo_n     = 16'd0;
					err_n     = 1'b1;
					ev        = spr_pkg::EV_TIMEOUT;
				end else begin
					tmo_n = tmo_q - 16'd1;
					ev    = spr_pkg::EV_IDLE;
				end
			end
			spr_pkg::CMD_RELEASE: begin
				if (rs_q == ws_q) begin
					ev = spr_pkg::EV_EMPTY;
				end else begin
					rs_n = next_slot(rs_q);
					ev   = spr_pkg::EV_RELEASED;
				end
			end
			spr_pkg::CMD_READ: begin
				if (rs_q == ws_q) begin
					ev = spr_pkg::EV_EMPTY;
				end else begin
					hit    = (idx < slot_len_q[rs_q]);
					mem_re = hit;
					ev     = spr_pkg::EV_READ;
				end
			end
			default: begin
				ev = spr_pkg::EV_IDLE;
			end
		endcase

		// The slot being filled reports its live count; a slot completed in
		// this very request is forwarded before its length register is written.
		if (rs_n == ws_n) begin
			oldest = cur_len_n;
		end else if (sl_we && (rs_n == ws_q)) begin
			oldest = len1;
		end else begin
			oldest = slot_len_q[rs_n];
		end
	end

	// Flow control: accept only if the output queue can hold everything in flight.
	assign inflight = {1'b0, fifo_cnt} + {2'b00, valid_s1} - {2'b00, fifo_pop};
	assign in_stall = (inflight >= 3'd2);
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_id_q    <= spr_pkg::DEVICE_ID_RST;
			bc_id_q     <= spr_pkg::BROADCAST_ID_RST;
			tmo_ticks_q <= spr_pkg::TIMEOUT_RST;
		end else if (cfg_we) begin
			case (spr_pkg::reg_idx_t'(cfg_index))
				spr_pkg::REG_DEVICE_ID:    dev_id_q    <= cfg_data[7:0];
				spr_pkg::REG_BROADCAST_ID: bc_id_q     <= cfg_data[7:0];
				spr_pkg::REG_TIMEOUT:      tmo_ticks_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_len_q <= 8'd0;
			ws_q      <= '0;
			rs_q      <= '0;
			rx_q      <= 1'b0;
			tmo_q     <= 16'd0;
			err_q     <= 1'b0;
			valid_s1  <= 1'b0;
			for (int i = 0; i < RING_SLOTS; i++) begin
				slot_len_q[i] <= 8'd0;
			end
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				cur_len_q <= cur_len_n;
				ws_q      <= ws_n;
				rs_q      <= rs_n;
				rx_q      <= rx_n;
				tmo_q     <= tmo_n;
				err_q     <= err_n;
				if (sl_we) begin
					slot_len_q[ws_q] <= len1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			len_byte_q                  <= len_byte_n;
			hit_s1                      <= hit;
			resp_s1.event_res           <= ev;
			resp_s1.packet_ready        <= (rs_n != ws_n) && !rx_n;
			resp_s1.receiving           <= rx_n;
			resp_s1.error_flag          <= err_n;
			resp_s1.read_data           <= 8'd0;
			resp_s1.oldest_length       <= oldest;
			resp_s1.cancel_sync_timeout <= cancel;
		end
	end

	logic [7:0]        mem_rdata;
	spr_pkg::spr_out_t resp_full;

	spr_pkt_mem #(
		.ADDR_W(ADDR_W)
	) u_mem (
		.clk   (clk),
		.we    (accept && mem_we),
		.waddr ({ws_q, cur_len_q}),
		.wdata (rx_b),
		.re    (accept && mem_re),
		.raddr ({rs_q, idx}),
		.rdata (mem_rdata)
	);

	always_comb begin
		resp_full           = resp_s1;
		resp_full.read_data = hit_s1 ? mem_rdata : 8'd0;
	end

	spr_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (valid_s1),
		.push_data (resp_full),
		.stall     (out_stall),
		.valid     (out_valid),
		.head      (out_data),
		.pop       (fifo_pop),
		.count     (fifo_cnt)
	);

endmodule

>>> rtl/core/spr_checker.sv
`include "assert_macros.svh"

module spr_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input spr_pkg::spr_in_t  in_data,
	input logic              out_valid,
	input logic              out_stall,
	input spr_pkg::spr_out_t out_data
);

	`SPR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "response dropped while stalled")
	`SPR_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_data), "stalled response changed")
	`SPR_ASSERT(a_ready_excl, out_valid |-> !(out_data.packet_ready && out_data.receiving), "packet ready during reception")
	`SPR_ASSERT(a_data_zero, (out_valid && (out_data.event_res != spr_pkg::EV_READ)) |-> (out_data.read_data == 8'd0), "read data without a read")
	`SPR_ASSERT(a_timeout_err, (out_valid && (out_data.event_res == spr_pkg::EV_TIMEOUT)) |-> (out_data.error_flag && !out_data.receiving), "timeout drop without error flag")

endmodule

bind servo_packet_receiver_core spr_checker u_spr_checker (.*);
